// File: hdl/pilr_pkg.sv
// pilr_pkg: shared constants and types for the pci intx link router
// used by pilr_byte_lane, pilr_route_table and pci_intx_link_router
`timescale 1ns / 1ps
`default_nettype none
package pilr_pkg;

   localparam int NUM_LANES  = 4;
   localparam int NUM_LINKS  = 4;
   localparam int ROUTE_W    = 4;
   localparam int LINK_W     = 2;

   localparam logic [7:0] ROUTE_BASE    = 8'h60;
   localparam logic [7:0] ROUTE_LAST    = 8'h63;
   localparam logic [7:0] ROUTE_OFF_BIT = 8'h80;
   localparam logic [3:0] ROUTE_MASK    = 4'hf;
   localparam logic [4:0] GSI_WRAP      = 5'd31;
   localparam logic [5:0] GSI_BASE      = 6'd16;

   typedef enum logic {
      ACTION_CFG_WRITE = 1'b0,
      ACTION_INTX      = 1'b1
   } action_type;

   typedef struct packed {
      logic               hit;
      logic [LINK_W-1:0]  link;
      logic [ROUTE_W-1:0] route;
   } lane_hit_type;

   typedef logic [NUM_LINKS-1:0][ROUTE_W-1:0] route_array_type;
   typedef lane_hit_type [NUM_LANES-1:0] lane_hits_type;

endpackage
`default_nettype wire

// File: hdl/pilr_byte_lane.sv
// pilr_byte_lane: decodes one byte of a config write word against the link routes
// depends on pilr_pkg
`timescale 1ns / 1ps
`default_nettype none
module pilr_byte_lane (
   input  wire logic [1:0]          lane_idx,
   input  wire logic [7:0]          cfg_address,
   input  wire logic [7:0]          cfg_byte,
   input  wire logic [2:0]          cfg_length,
   output pilr_pkg::lane_hit_type   lane_hit
);

   logic [8:0] offset;
   logic       enabled;
   logic       in_range;

   always_comb begin
      offset   = {1'b0, cfg_address} + {7'd0, lane_idx};
      enabled  = {1'b0, lane_idx} < cfg_length;
      in_range = (offset >= {1'b0, pilr_pkg::ROUTE_BASE}) &&
                 (offset <= {1'b0, pilr_pkg::ROUTE_LAST});
      lane_hit.hit  = enabled && in_range;
      lane_hit.link = offset[pilr_pkg::LINK_W-1:0];
      if ((cfg_byte & pilr_pkg::ROUTE_OFF_BIT) != 8'd0) begin
         lane_hit.route = '0;
      end else begin
         lane_hit.route = cfg_byte[3:0] & pilr_pkg::ROUTE_MASK;
      end
   end

endmodule
`default_nettype wire

// File: hdl/pilr_route_table.sv
// pilr_route_table: link route registers, merges the byte lane hits of a write
// depends on pilr_pkg
`timescale 1ns / 1ps
`default_nettype none
module pilr_route_table (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    write_en,
   input  wire pilr_pkg::lane_hits_type lane_hits,
   input  wire logic [pilr_pkg::LINK_W-1:0]  read_link,
   output logic [pilr_pkg::ROUTE_W-1:0]      read_route
);

   pilr_pkg::route_array_type routes_ff;
   pilr_pkg::route_array_type routes_in;

   always_comb begin
      routes_in = routes_ff;
      if (write_en) begin
         for (int k = 0; k < pilr_pkg::NUM_LANES; k++) begin
            if (lane_hits[k].hit) begin
               routes_in[lane_hits[k].link] = lane_hits[k].route;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         routes_ff <= '0;
      end else begin
         routes_ff <= routes_in;
      end
   end

   assign read_route = routes_ff[read_link];

endmodule
`default_nettype wire

// File: hdl/pci_intx_link_router.sv
// pci_intx_link_router: top level of the pci interrupt link router
// depends on pilr_pkg, pilr_byte_lane and pilr_route_table
//
// Four byte lanes decode a config write word in parallel and a merge stage
// updates the four link route registers in the cycle the word is accepted.
// An interrupt line word is turned into its swizzled gsi and routed isa irq
// and is held in the output register from the cycle after acceptance. One word is
// taken per cycle; a config write is taken even while a result is stalled,
// an interrupt word waits until the output register is free or draining.
`timescale 1ns / 1ps
`default_nettype none
module pci_intx_link_router (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_cfg_address,
   input  wire logic [31:0] req_cfg_data,
   input  wire logic [2:0]  req_cfg_length,
   input  wire logic [6:0]  req_intx_line,
   input  wire logic        req_line_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_gsi_number,
   output logic             rsp_gsi_level,
   output logic             rsp_isa_valid,
   output logic [3:0]       rsp_isa_number
);

   pilr_pkg::lane_hits_type lane_hits;
   logic        req_accept;
   logic        is_intx;
   logic        cfg_write;
   logic [4:0]  dev;
   logic [1:0]  pin;
   logic [4:0]  gsi_low;
   logic [1:0]  link;
   logic [3:0]  route;

   logic        valid_ff, valid_in;
   logic [5:0]  gsi_ff, gsi_in;
   logic        level_ff, level_in;
   logic        isa_valid_ff, isa_valid_in;
   logic [3:0]  isa_ff, isa_in;

   assign is_intx    = (req_action == pilr_pkg::ACTION_INTX);
   assign req_stall  = valid_ff && rsp_stall && is_intx;
   assign req_accept = req_valid && !req_stall;
   assign cfg_write  = req_accept && !is_intx;

   for (genvar g = 0; g < pilr_pkg::NUM_LANES; g++) begin : g_lane
      pilr_byte_lane u_lane (
         .lane_idx    (2'(g)),
         .cfg_address (req_cfg_address),
         .cfg_byte    (req_cfg_data[8*g +: 8]),
         .cfg_length  (req_cfg_length),
         .lane_hit    (lane_hits[g])
      );
   end

   pilr_route_table u_table (
      .clock      (clock),
      .reset      (reset),
      .write_en   (cfg_write),
      .lane_hits  (lane_hits),
      .read_link  (link),
      .read_route (route)
   );

   always_comb begin
      dev     = req_intx_line[6:2];
      pin     = req_intx_line[1:0];
      gsi_low = ({dev[2:0], 2'b00} + {3'd0, dev[4:3]} + {3'd0, pin}) & pilr_pkg::GSI_WRAP;
      link    = dev[1:0] + pin;

      valid_in     = valid_ff && rsp_stall;
      gsi_in       = gsi_ff;
      level_in     = level_ff;
      isa_valid_in = isa_valid_ff;
      isa_in       = isa_ff;
      if (req_accept && is_intx) begin
         valid_in     = 1'b1;
         gsi_in       = {1'b0, gsi_low} + pilr_pkg::GSI_BASE;
         level_in     = req_line_level;
         isa_valid_in = (route != 4'd0);
         isa_in       = route;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      gsi_ff       <= gsi_in;
      level_ff     <= level_in;
      isa_valid_ff <= isa_valid_in;
      isa_ff       <= isa_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_gsi_number = gsi_ff;
   assign rsp_gsi_level  = level_ff;
   assign rsp_isa_valid  = isa_valid_ff;
   assign rsp_isa_number = isa_ff;

   a_intx_gives_word : assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_intx) |=> rsp_valid)
      else $error("interrupt word did not produce a result");

   a_cfg_no_word : assert property (@(posedge clock) disable iff (reset)
      (cfg_write && (!rsp_valid || !rsp_stall)) |=> !rsp_valid)
      else $error("config write produced a result");

   a_gsi_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gsi_number >= pilr_pkg::GSI_BASE && rsp_gsi_number <= 6'd47))
      else $error("gsi out of range");

   a_isa_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_isa_valid == (rsp_isa_number != 4'd0)))
      else $error("isa valid flag disagrees with route");

endmodule
`default_nettype wire
